/* hw/rtl/pipeline_hazard_bubble_counter_core_defines.svh */
// ----------------------------------------------------------------------------
// Hazard bubble counter assertion macros
// Shared assertion shorthands for the hazard bubble counter checkers.
// ----------------------------------------------------------------------------
`ifndef PIPELINE_HAZARD_BUBBLE_COUNTER_CORE_DEFINES_SVH
`define PIPELINE_HAZARD_BUBBLE_COUNTER_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define HBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define HBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// Hazard bubble counter package
// Constants, shared types and the instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbc_pkg;

  localparam int HIST_DEPTH  = 8;
  localparam int FILL_CYCLES = 7;

  localparam logic [5:0] TAG_EMPTY = 6'h3f;
  localparam logic [5:0] TAG_HILO  = 6'd33;
  localparam logic [5:0] TAG_RA    = 6'd31;

  // Opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_TRAP    = 6'h1a;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  // Trap codes
  localparam logic [3:0] TRAP_HALT  = 4'h0;
  localparam logic [3:0] TRAP_PRINT = 4'h1;
  localparam logic [3:0] TRAP_READ  = 4'h5;
  localparam logic [3:0] TRAP_NOP   = 4'ha;

  // Pipeline stages
  localparam logic [2:0] STG_NONE = 3'd0;
  localparam logic [2:0] STG_ID   = 3'd3;
  localparam logic [2:0] STG_EX1  = 3'd4;
  localparam logic [2:0] STG_EX2  = 3'd5;
  localparam logic [2:0] STG_MEM2 = 3'd7;

  typedef struct packed {
    logic       src0_v;
    logic [5:0] src0;
    logic [2:0] need0;
    logic       src1_v;
    logic [5:0] src1;
    logic [2:0] need1;
    logic       push_v;
    logic [5:0] push_tag;
    logic [2:0] push_rdy;
    logic       flush;
    logic       unimp;
  } dec_t;

  typedef struct packed {
    logic       push;
    logic [5:0] tag;
    logic [2:0] rdy;
  } hist_push_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] rdy;
  } hist_hit_t;

  function automatic dec_t decode(logic [31:0] w, logic taken);
    dec_t       d;
    logic [5:0] op;
    logic [5:0] fn;
    logic [5:0] rs;
    logic [5:0] rt;
    logic [5:0] rd;
    op = w[31:26];
    fn = w[5:0];
    rs = {1'b0, w[25:21]};
    rt = {1'b0, w[20:16]};
    rd = {1'b0, w[15:11]};
    d = '0;
    d.push_tag = TAG_EMPTY;
    d.push_rdy = STG_NONE;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL, FN_SRA: begin
            d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
            d.push_v = 1'b1; d.push_tag = rd; d.push_rdy = STG_EX2;
          end
          FN_JR: begin
            d.flush  = 1'b1;
            d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_ID;
            d.push_v = 1'b1;
          end
          FN_MFHI, FN_MFLO: begin
            d.src0_v = 1'b1; d.src0 = TAG_HILO; d.need0 = STG_EX1;
            d.push_v = 1'b1; d.push_tag = rd; d.push_rdy = STG_MEM2;
          end
          FN_MULT, FN_DIV: begin
            d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
            d.src1_v = 1'b1; d.src1 = rt; d.need1 = STG_EX1;
            d.push_v = 1'b1; d.push_tag = TAG_HILO; d.push_rdy = STG_MEM2;
          end
          FN_ADDU, FN_SUBU, FN_SLT: begin
            d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
            d.src1_v = 1'b1; d.src1 = rt; d.need1 = STG_EX1;
            d.push_v = 1'b1; d.push_tag = rd; d.push_rdy = STG_EX2;
          end
          default: d.unimp = 1'b1;
        endcase
      end
      OP_J: begin
        d.flush = 1'b1; d.push_v = 1'b1;
      end
      OP_JAL: begin
        d.flush = 1'b1;
        d.push_v = 1'b1; d.push_tag = TAG_RA; d.push_rdy = STG_ID;
      end
      OP_BEQ, OP_BNE: begin
        d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_ID;
        d.src1_v = 1'b1; d.src1 = rt; d.need1 = STG_ID;
        d.push_v = 1'b1;
        d.flush  = taken;
      end
      OP_ADDIU, OP_ANDI: begin
        d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
        d.push_v = 1'b1; d.push_tag = rt; d.push_rdy = STG_EX2;
      end
      OP_LUI: begin
        d.push_v = 1'b1; d.push_tag = rt; d.push_rdy = STG_EX2;
      end
      OP_TRAP: begin
        case (w[3:0])
          TRAP_HALT, TRAP_NOP: d.push_v = 1'b0;
          TRAP_PRINT: begin
            d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
            d.push_v = 1'b1;
          end
          TRAP_READ: begin
            d.push_v = 1'b1; d.push_tag = rt; d.push_rdy = STG_EX2;
          end
          default: d.unimp = 1'b1;
        endcase
      end
      OP_LW: begin
        d.src0_v = 1'b1; d.src0 = rs; d.need0 = STG_EX1;
        d.push_v = 1'b1; d.push_tag = rt; d.push_rdy = STG_MEM2;
      end
      OP_SW: begin
        d.src0_v = 1'b1; d.src0 = rt; d.need0 = STG_MEM2;
        d.src1_v = 1'b1; d.src1 = rs; d.need1 = STG_MEM2;
        d.push_v = 1'b1;
      end
      default: d.unimp = 1'b1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hbc_hist.sv */
// ----------------------------------------------------------------------------
// Hazard bubble counter history
// Shift history of destination tags and ready stages with a newest-first
// tag search.
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_hist (
  input  wire                     clk,
  input  wire                     rst,
  input  wire hbc_pkg::hist_push_t push_in,
  input  wire logic [5:0]         query_tag,
  output hbc_pkg::hist_hit_t      hit_out
);

  logic [5:0] tags [hbc_pkg::HIST_DEPTH];
  logic [2:0] rdys [hbc_pkg::HIST_DEPTH];

  // Age every slot (floor at zero), shift by one, insert the new slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hbc_pkg::HIST_DEPTH; i++) begin
        tags[i] <= '0;
        rdys[i] <= '0;
      end
    end else if (push_in.push) begin
      for (int i = 1; i < hbc_pkg::HIST_DEPTH; i++) begin
        tags[i] <= tags[i-1];
        rdys[i] <= (rdys[i-1] != 3'd0) ? rdys[i-1] - 3'd1 : 3'd0;
      end
      tags[0] <= push_in.tag;
      rdys[0] <= push_in.rdy;
    end
  end

  // Newest match wins: scan oldest to newest, last hit overrides.
  always_comb begin
    hit_out = '0;
    for (int i = hbc_pkg::HIST_DEPTH - 1; i >= 0; i--) begin
      if (tags[i] == query_tag) begin
        hit_out.hit = 1'b1;
        hit_out.rdy = rdys[i];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hbc_satadd.sv */
// ----------------------------------------------------------------------------
// Hazard bubble counter saturating adder
// Shared 32-bit adder that clamps at all ones on carry out.
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_satadd (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  logic [32:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};
  assign y   = sum[32] ? '1 : sum[31:0];

endmodule

`default_nettype wire

/* hw/rtl/pipeline_hazard_bubble_counter_core.sv */
// Sequence from input beat to output valid: source checks, bubble shifts, one push,
//   six adder steps, one handoff.
// The input is ready only while idle, and a held output beat stalls the handoff of
//   the next result.
// Reset (rst, synchronous): history tags and ready stages cleared to zero, bubble,
//   flush and instruction totals cleared (cyc is not), no output beat pending.
// ----------------------------------------------------------------------------
// Pipeline hazard bubble counter core
// Decodes MIPS words, tracks an eight-slot destination history and reports
// bubble, flush, instruction and cycle totals per instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module pipeline_hazard_bubble_counter_core (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [31:0]  s_tdata,   // [31:0] instr_word
  input  wire  [0:0]   s_tuser,   // [0] branch_taken
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [135:0] m_tdata,   // [3:0] bubbles_now, [35:4] bubble_count,
                                  // [67:36] flush_count, [99:68] instr_count,
                                  // [131:100] cycle_count, [135:132] zero
  output logic [0:0]   m_tuser    // [0] unimplemented
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input beat
  localparam logic [2:0] ST_CHK  = 3'd1;  // search history for one source
  localparam logic [2:0] ST_BUB  = 3'd2;  // shift in one bubble per cycle
  localparam logic [2:0] ST_PUSH = 3'd3;  // insert the instruction's own slot
  localparam logic [2:0] ST_ACC  = 3'd4;  // counter updates on the shared adder
  localparam logic [2:0] ST_DONE = 3'd5;  // hand result to the output register

  // Shared adder steps
  localparam logic [2:0] AS_INSTR = 3'd0;
  localparam logic [2:0] AS_BUB   = 3'd1;
  localparam logic [2:0] AS_FLUSH = 3'd2;
  localparam logic [2:0] AS_FILL  = 3'd3;
  localparam logic [2:0] AS_CBUB  = 3'd4;
  localparam logic [2:0] AS_CFL   = 3'd5;

  logic [2:0]          state;
  hbc_pkg::dec_t       dec;
  logic                src_sel;
  logic [2:0]          bub_left;
  logic [3:0]          bub_now;
  logic [2:0]          acc_step;
  logic [31:0]         bubble_total;
  logic [31:0]         flush_total;
  logic [31:0]         instr_total;
  logic [31:0]         cyc;

  hbc_pkg::hist_push_t hpush;
  hbc_pkg::hist_hit_t  hhit;
  logic [5:0]          cur_src;
  logic [2:0]          cur_need;
  logic                cur_v;
  logic                stall_hit;
  logic [31:0]         add_a;
  logic [31:0]         add_b;
  logic [31:0]         add_y;
  logic                in_beat;

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;

  // Current source under check
  assign cur_src   = src_sel ? dec.src1  : dec.src0;
  assign cur_need  = src_sel ? dec.need1 : dec.need0;
  assign cur_v     = src_sel ? dec.src1_v : dec.src0_v;
  assign stall_hit = cur_v && hhit.hit && (hhit.rdy > cur_need);

  // History writes: a bubble is an empty slot with ready stage zero
  always_comb begin
    hpush.push = (state == ST_BUB) || ((state == ST_PUSH) && dec.push_v);
    hpush.tag  = (state == ST_BUB) ? hbc_pkg::TAG_EMPTY : dec.push_tag;
    hpush.rdy  = (state == ST_BUB) ? hbc_pkg::STG_NONE  : dec.push_rdy;
  end

  hbc_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .push_in   (hpush),
    .query_tag (cur_src),
    .hit_out   (hhit)
  );

  // Operand select for the shared adder; cycle count builds up in cyc
  always_comb begin
    case (acc_step)
      AS_INSTR: begin add_a = instr_total;  add_b = 32'd1; end
      AS_BUB:   begin add_a = bubble_total; add_b = {28'd0, bub_now}; end
      AS_FLUSH: begin add_a = flush_total;  add_b = {30'd0, dec.flush, 1'b0}; end
      AS_FILL:  begin add_a = instr_total;  add_b = 32'(hbc_pkg::FILL_CYCLES); end
      AS_CBUB:  begin add_a = cyc;          add_b = bubble_total; end
      AS_CFL:   begin add_a = cyc;          add_b = flush_total; end
      default:  begin add_a = '0;           add_b = '0; end
    endcase
  end

  hbc_satadd u_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      src_sel      <= 1'b0;
      bub_left     <= '0;
      bub_now      <= '0;
      acc_step     <= AS_INSTR;
      bubble_total <= '0;
      flush_total  <= '0;
      instr_total  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a new one is handed over now
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            src_sel  <= 1'b0;
            bub_now  <= '0;
            acc_step <= AS_INSTR;
            state    <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (stall_hit) begin
            bub_left <= hhit.rdy - cur_need;
            state    <= ST_BUB;
          end else if (!src_sel) begin
            src_sel <= 1'b1;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_BUB: begin
          bub_left <= bub_left - 3'd1;
          bub_now  <= bub_now + 4'd1;
          // Last bubble: move on to the next source or to the push
          if (bub_left == 3'd1) begin
            if (!src_sel) begin
              src_sel <= 1'b1;
              state   <= ST_CHK;
            end else begin
              state <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          case (acc_step)
            AS_INSTR: instr_total  <= add_y;
            AS_BUB:   bubble_total <= add_y;
            AS_FLUSH: flush_total  <= add_y;
            default:  cyc          <= add_y;
          endcase
          if (acc_step == AS_CFL) begin
            state <= ST_DONE;
          end else begin
            acc_step <= acc_step + 3'd1;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the decoded word on the input beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      dec <= hbc_pkg::decode(s_tdata, s_tuser[0]);
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, cyc, instr_total, flush_total, bubble_total, bub_now};
      m_tuser <= dec.unimp;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hbc_checker.sv */
// ----------------------------------------------------------------------------
// Hazard bubble counter checker
// Port-level checks on the hazard bubble counter core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pipeline_hazard_bubble_counter_core_defines.svh"

module hbc_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_tvalid,
  input wire         s_tready,
  input wire [31:0]  s_tdata,
  input wire [0:0]   s_tuser,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [135:0] m_tdata,
  input wire [0:0]   m_tuser
);

  `HBC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `HBC_ASSERT(a_busy_after_in, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `HBC_ASSERT(a_cyc_ge_instr, clk, rst, m_tvalid |-> (m_tdata[131:100] >= m_tdata[99:68]))
  `HBC_ASSERT(a_unimp_no_bub, clk, rst, m_tvalid && m_tuser[0] |-> (m_tdata[3:0] == 4'd0))
  `HBC_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_tvalid && s_tready)

endmodule

bind pipeline_hazard_bubble_counter_core hbc_checker u_hbc_checker (.*);

`default_nettype wire
